// ===== hdl/plob_pkg.sv =====
// shared constants, types and helper functions of the price level order book
package plob_pkg;

    localparam int LVL_BITS = 10;
    localparam int LEVELS   = 1 << LVL_BITS;
    localparam int NUMW     = 35;
    localparam int DENW     = 32;
    localparam int MAGW     = NUMW - 1;
    localparam int CNTW     = $clog2(MAGW);
    localparam int PRODW    = LVL_BITS + 1 + 32;
    localparam int SUMW     = PRODW + 1;
    localparam int ENSW     = LVL_BITS + 34;

    localparam logic [LVL_BITS-1:0] LVL_MAX = {LVL_BITS{1'b1}};
    localparam logic [MAGW:0]       MID_W   = (MAGW + 1)'(LEVELS / 2);
    localparam logic signed [LVL_BITS:0] MID_S = (LVL_BITS + 1)'(LEVELS / 2);

    localparam logic [1:0] ACT_BID   = 2'd0;
    localparam logic [1:0] ACT_ASK   = 2'd1;
    localparam logic [1:0] ACT_PAIR  = 2'd2;
    localparam logic [1:0] ACT_RESET = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_CLR,
        S_DIVW,
        S_SCRD,
        S_SCCK,
        S_ORD,
        S_OMB,
        S_OMA,
        S_OAD
    } t_state;

    typedef enum logic [3:0] {
        OP_ENS_A,
        OP_ENS_B,
        OP_PRI_B,
        OP_PRI_A,
        OP_IDX_A,
        OP_IDX_B,
        OP_PUT_LVL,
        OP_PUT_BID,
        OP_PUT_ASK,
        OP_FIN_A,
        OP_FIN_B,
        OP_RST,
        OP_REPORT
    } t_op;

    typedef struct packed {
        logic                   start;
        logic signed [NUMW-1:0] num;
        logic [DENW-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [LVL_BITS-1:0] idx;
    } t_div_rsp;

    function automatic t_op plob_op(input logic [1:0] act, input logic [3:0] pc);
        t_op op;
        op = OP_REPORT;
        case (act)
            ACT_BID, ACT_ASK: begin
                case (pc)
                    4'd0:    op = OP_ENS_A;
                    4'd1:    op = OP_IDX_A;
                    4'd2:    op = OP_PUT_LVL;
                    default: op = OP_REPORT;
                endcase
            end
            ACT_PAIR: begin
                case (pc)
                    4'd0:    op = OP_ENS_A;
                    4'd1:    op = OP_ENS_B;
                    4'd2:    op = OP_PRI_B;
                    4'd3:    op = OP_PRI_A;
                    4'd4:    op = OP_ENS_A;
                    4'd5:    op = OP_IDX_A;
                    4'd6:    op = OP_PUT_BID;
                    4'd7:    op = OP_ENS_B;
                    4'd8:    op = OP_IDX_B;
                    4'd9:    op = OP_PUT_ASK;
                    4'd10:   op = OP_IDX_A;
                    4'd11:   op = OP_FIN_A;
                    4'd12:   op = OP_IDX_B;
                    4'd13:   op = OP_FIN_B;
                    default: op = OP_REPORT;
                endcase
            end
            default: begin
                case (pc)
                    4'd0:    op = OP_RST;
                    default: op = OP_REPORT;
                endcase
            end
        endcase
        return op;
    endfunction

    function automatic logic signed [31:0] plob_sat(input logic signed [SUMW-1:0] v);
        logic signed [31:0] r;
        if (v > SUMW'(64'sd2147483647)) begin
            r = 32'sh7fffffff;
        end else if (v < -SUMW'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] plob_clamp(input logic signed [31:0] q);
        return q[31] ? 31'd0 : q[30:0];
    endfunction

endpackage

// ===== hdl/plob_store.sv =====
// one side of the book: level quantity memory with registered read
module plob_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [plob_pkg::LVL_BITS-1:0] i_waddr,
    input  logic [30:0]                   i_wdata,
    input  logic [plob_pkg::LVL_BITS-1:0] i_raddr,
    output logic [30:0]                   o_rdata
);

    logic [30:0] r_mem [plob_pkg::LEVELS];
    logic [30:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/plob_div.sv =====
// shared bit-serial divider mapping a price offset to a clamped level index
module plob_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plob_pkg::t_div_req i_req,
    output plob_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_neg;
    logic [plob_pkg::CNTW-1:0]     r_cnt;
    logic [plob_pkg::MAGW-1:0]     r_quo;
    logic [plob_pkg::DENW-1:0]     r_rem;
    logic [plob_pkg::DENW-1:0]     r_den;

    logic signed [plob_pkg::NUMW-1:0] w_neg_num;
    logic [plob_pkg::MAGW-1:0]        w_mag;
    logic [plob_pkg::DENW:0]          w_tr;
    logic [plob_pkg::DENW:0]          w_sub;
    logic [plob_pkg::MAGW:0]          w_qr;
    logic [plob_pkg::MAGW:0]          w_qp;

    assign w_neg_num = -i_req.num;
    assign w_mag = i_req.num[plob_pkg::NUMW-1] ? w_neg_num[plob_pkg::MAGW-1:0]
                                               : i_req.num[plob_pkg::MAGW-1:0];
    assign w_tr  = {r_rem, r_quo[plob_pkg::MAGW-1]};
    assign w_sub = w_tr - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= plob_pkg::CNTW'(plob_pkg::MAGW - 1);
                r_quo  <= w_mag;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_neg  <= i_req.num[plob_pkg::NUMW-1];
            end else if (r_busy) begin
                if (!w_sub[plob_pkg::DENW]) begin
                    r_rem <= w_sub[plob_pkg::DENW-1:0];
                    r_quo <= {r_quo[plob_pkg::MAGW-2:0], 1'b1};
                end else begin
                    r_rem <= w_tr[plob_pkg::DENW-1:0];
                    r_quo <= {r_quo[plob_pkg::MAGW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // floor for negative offsets, then clamp to the level range
    assign w_qr = {1'b0, r_quo} + (plob_pkg::MAGW + 1)'(r_rem != '0);
    assign w_qp = {1'b0, r_quo};

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            if (w_qr >= plob_pkg::MID_W) begin
                o_rsp.idx = '0;
            end else begin
                o_rsp.idx = plob_pkg::LVL_BITS'(plob_pkg::MID_W - w_qr);
            end
        end else begin
            if (w_qp >= plob_pkg::MID_W) begin
                o_rsp.idx = plob_pkg::LVL_MAX;
            end else begin
                o_rsp.idx = plob_pkg::LVL_BITS'(plob_pkg::MID_W + w_qp);
            end
        end
    end

endmodule

// ===== hdl/price_level_order_book_core.sv =====
// top level of the price level order book: sequencer, book state and result register
//
// Input channel i_in_valid / o_in_ready moves one update (action, two prices, two
// quantities) per transfer. Output channel o_out_valid / i_out_ready moves one
// result per item: accept flag, best bid and ask with sizes, recenter count.
// Tick size is written through i_cfg_wr_en / i_cfg_wr_data; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// An item runs under a small sequencer that reuses one serial divider for each
// price-to-level mapping and one multiplier for the quote prices.
// A scan for the next nonzero level runs S_SCRD then S_SCCK per level visited.
// Any recenter, and the reset action, sweeps both level memories.
// After i_rst_n the same clearing pass runs before o_in_ready rises.
// The result sits in an output register; a new item is taken while it waits,
// and a finished item holds in the sequencer until the receiver takes the old one.
module price_level_order_book_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [30:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_price_a,
    input  logic signed [31:0] i_qty_a,
    input  logic signed [31:0] i_price_b,
    input  logic signed [31:0] i_qty_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_accepted,
    output logic               o_quote_valid,
    output logic signed [31:0] o_best_bid_price,
    output logic [30:0]        o_best_bid_size,
    output logic signed [31:0] o_best_ask_price,
    output logic [30:0]        o_best_ask_size,
    output logic [31:0]        o_recenter_total
);

    localparam int LB = plob_pkg::LVL_BITS;

    plob_pkg::t_state r_st, n_st;

    logic [30:0]        r_tick;
    logic               r_boot;
    logic [LB-1:0]      r_ci;
    logic [3:0]         r_pc;
    logic [1:0]         r_act;
    logic signed [31:0] r_pa, r_qa, r_pb, r_qb;
    logic               r_acc;
    logic signed [31:0] r_base;
    logic               r_mapped;
    logic [31:0]        r_cnt;
    logic               r_bb_ok, r_ba_ok, r_pb_ok, r_pa_ok;
    logic [LB-1:0]      r_bb, r_ba, r_pbs, r_pas;
    logic [LB-1:0]      r_idx;
    logic [LB-1:0]      r_si;
    logic               r_sside;
    logic [30:0]        r_bsz, r_asz;
    logic signed [plob_pkg::PRODW-1:0] r_prod;
    logic signed [31:0] r_bp;
    logic               r_ovalid;
    logic               r_oacc, r_oqv;
    logic signed [31:0] r_obp, r_oap;
    logic [30:0]        r_obs, r_oas;
    logic [31:0]        r_ocnt;

    plob_pkg::t_op      w_op;
    logic [30:0]        w_tick;
    logic signed [31:0] w_price;
    logic signed [32:0] w_diff;
    logic [32:0]        w_absd;
    logic               w_need;
    logic               w_in_ok;
    logic               w_side;
    logic [LB-1:0]      w_addr;
    logic [30:0]        w_qty;
    logic               w_wen;
    logic               w_ok;
    logic [LB-1:0]      w_slot;
    logic               w_improve;
    logic               w_scan;
    logic               w_scan_run;
    logic [30:0]        w_rd;
    logic               w_scan_end;
    logic               w_out_adv;
    logic [LB-1:0]      w_mslot;
    logic signed [LB:0] w_off;
    logic signed [plob_pkg::PRODW-1:0] w_prod;
    logic signed [31:0] w_sat;

    logic          bid_we, ask_we;
    logic [LB-1:0] bid_waddr, ask_waddr, bid_raddr, ask_raddr;
    logic [30:0]   bid_wdata, ask_wdata, bid_rd, ask_rd;

    plob_pkg::t_div_req div_req;
    plob_pkg::t_div_rsp div_rsp;

    plob_store u_bid (
        .i_clk   (i_clk),
        .i_we    (bid_we),
        .i_waddr (bid_waddr),
        .i_wdata (bid_wdata),
        .i_raddr (bid_raddr),
        .o_rdata (bid_rd)
    );

    plob_store u_ask (
        .i_clk   (i_clk),
        .i_we    (ask_we),
        .i_waddr (ask_waddr),
        .i_wdata (ask_wdata),
        .i_raddr (ask_raddr),
        .o_rdata (ask_rd)
    );

    plob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign w_op    = plob_pkg::plob_op(r_act, r_pc);
    assign w_tick  = (r_tick == '0) ? 31'd1 : r_tick;
    assign w_price = (w_op == plob_pkg::OP_ENS_B || w_op == plob_pkg::OP_IDX_B) ? r_pb : r_pa;
    assign w_diff  = {w_price[31], w_price} - {r_base[31], r_base};
    assign w_absd  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_need  = !r_mapped ||
                     (plob_pkg::ENSW'(w_absd) > plob_pkg::ENSW'({w_tick, {(LB - 2){1'b0}}}));

    always_comb begin
        case (i_action)
            plob_pkg::ACT_BID, plob_pkg::ACT_ASK: w_in_ok = (i_price_a > 0) && !i_qty_a[31];
            plob_pkg::ACT_PAIR: w_in_ok = (i_price_a > 0) && (i_price_b > 0) &&
                                          (i_price_b >= i_price_a);
            default: w_in_ok = 1'b1;
        endcase
    end

    // level write and best tracking for the current op
    always_comb begin
        w_side = 1'b0;
        w_addr = r_idx;
        w_qty  = plob_pkg::plob_clamp(r_qa);
        w_wen  = 1'b0;
        case (w_op)
            plob_pkg::OP_PRI_B: begin
                w_addr = r_pbs;
                w_qty  = '0;
                w_wen  = r_pb_ok;
            end
            plob_pkg::OP_PRI_A: begin
                w_side = 1'b1;
                w_addr = r_pas;
                w_qty  = '0;
                w_wen  = r_pa_ok;
            end
            plob_pkg::OP_PUT_LVL: begin
                w_side = r_act[0];
                w_wen  = 1'b1;
            end
            plob_pkg::OP_PUT_BID: begin
                w_wen = 1'b1;
            end
            plob_pkg::OP_PUT_ASK: begin
                w_side = 1'b1;
                w_qty  = plob_pkg::plob_clamp(r_qb);
                w_wen  = 1'b1;
            end
            default: begin
                w_wen = 1'b0;
            end
        endcase
    end

    assign w_ok      = w_side ? r_ba_ok : r_bb_ok;
    assign w_slot    = w_side ? r_ba : r_bb;
    assign w_improve = w_wen && (w_qty != '0) &&
                       (!w_ok || (w_side ? (w_slot > w_addr) : (w_slot < w_addr)));
    assign w_scan    = w_wen && (w_qty == '0) && w_ok && (w_slot == w_addr);
    assign w_scan_run = w_scan && !(!w_side && (w_addr == '0));

    assign w_rd       = r_sside ? ask_rd : bid_rd;
    assign w_scan_end = r_sside ? (r_si == plob_pkg::LVL_MAX) : (r_si == '0);
    assign w_out_adv  = !r_ovalid || i_out_ready;

    assign w_mslot = (r_st == plob_pkg::S_OMA) ? r_ba : r_bb;
    assign w_off   = $signed({1'b0, w_mslot}) - plob_pkg::MID_S;
    assign w_prod  = w_off * $signed({1'b0, w_tick});
    assign w_sat   = plob_pkg::plob_sat(plob_pkg::SUMW'(r_base) + plob_pkg::SUMW'(r_prod));

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            plob_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_st = plob_pkg::S_DISP;
                end
            end
            plob_pkg::S_DISP: begin
                case (w_op)
                    plob_pkg::OP_ENS_A, plob_pkg::OP_ENS_B: begin
                        n_st = w_need ? plob_pkg::S_CLR : plob_pkg::S_DISP;
                    end
                    plob_pkg::OP_PRI_B, plob_pkg::OP_PRI_A, plob_pkg::OP_PUT_LVL,
                    plob_pkg::OP_PUT_BID, plob_pkg::OP_PUT_ASK: begin
                        n_st = w_scan_run ? plob_pkg::S_SCRD : plob_pkg::S_DISP;
                    end
                    plob_pkg::OP_IDX_A, plob_pkg::OP_IDX_B: n_st = plob_pkg::S_DIVW;
                    plob_pkg::OP_RST:    n_st = plob_pkg::S_CLR;
                    plob_pkg::OP_REPORT: n_st = plob_pkg::S_ORD;
                    default:             n_st = plob_pkg::S_DISP;
                endcase
            end
            plob_pkg::S_CLR: begin
                if (r_ci == plob_pkg::LVL_MAX) begin
                    n_st = r_boot ? plob_pkg::S_IDLE : plob_pkg::S_DISP;
                end
            end
            plob_pkg::S_DIVW: begin
                if (div_rsp.done) begin
                    n_st = plob_pkg::S_DISP;
                end
            end
            plob_pkg::S_SCRD: n_st = plob_pkg::S_SCCK;
            plob_pkg::S_SCCK: begin
                n_st = ((w_rd != '0) || w_scan_end) ? plob_pkg::S_DISP : plob_pkg::S_SCRD;
            end
            plob_pkg::S_ORD: n_st = plob_pkg::S_OMB;
            plob_pkg::S_OMB: n_st = plob_pkg::S_OMA;
            plob_pkg::S_OMA: n_st = plob_pkg::S_OAD;
            plob_pkg::S_OAD: begin
                if (w_out_adv) begin
                    n_st = plob_pkg::S_IDLE;
                end
            end
            default: n_st = plob_pkg::S_IDLE;
        endcase
    end

    // memory and divider control
    always_comb begin
        bid_we        = 1'b0;
        ask_we        = 1'b0;
        bid_waddr     = w_addr;
        ask_waddr     = w_addr;
        bid_wdata     = w_qty;
        ask_wdata     = w_qty;
        bid_raddr     = r_si;
        ask_raddr     = r_si;
        div_req.start = 1'b0;
        div_req.num   = {w_diff[32], w_diff, 1'b0} + {4'b0, w_tick};
        div_req.den   = {w_tick, 1'b0};
        case (r_st)
            plob_pkg::S_CLR: begin
                bid_we    = 1'b1;
                ask_we    = 1'b1;
                bid_waddr = r_ci;
                ask_waddr = r_ci;
                bid_wdata = '0;
                ask_wdata = '0;
            end
            plob_pkg::S_DISP: begin
                bid_we        = w_wen && !w_side;
                ask_we        = w_wen && w_side;
                div_req.start = (w_op == plob_pkg::OP_IDX_A) || (w_op == plob_pkg::OP_IDX_B);
            end
            plob_pkg::S_ORD: begin
                bid_raddr = r_bb;
                ask_raddr = r_ba;
            end
            default: begin
                bid_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= plob_pkg::S_CLR;
            r_boot   <= 1'b1;
            r_ci     <= '0;
            r_pc     <= '0;
            r_tick   <= 31'd1;
            r_base   <= '0;
            r_mapped <= 1'b0;
            r_cnt    <= '0;
            r_bb_ok  <= 1'b0;
            r_ba_ok  <= 1'b0;
            r_pb_ok  <= 1'b0;
            r_pa_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_wr_en) begin
                r_tick <= i_cfg_wr_data;
            end
            if (r_st == plob_pkg::S_OAD && w_out_adv) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                plob_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_act <= i_action;
                        r_pa  <= i_price_a;
                        r_qa  <= i_qty_a;
                        r_pb  <= i_price_b;
                        r_qb  <= i_qty_b;
                        r_acc <= w_in_ok;
                        r_pc  <= w_in_ok ? 4'd0 : 4'd15;
                    end
                end
                plob_pkg::S_DISP: begin
                    if (w_op != plob_pkg::OP_REPORT) begin
                        r_pc <= r_pc + 4'd1;
                    end
                    case (w_op)
                        plob_pkg::OP_ENS_A, plob_pkg::OP_ENS_B: begin
                            if (w_need) begin
                                r_base   <= w_price;
                                r_mapped <= 1'b1;
                                r_cnt    <= r_cnt + 32'd1;
                                r_bb_ok  <= 1'b0;
                                r_ba_ok  <= 1'b0;
                                r_pb_ok  <= 1'b0;
                                r_pa_ok  <= 1'b0;
                                r_ci     <= '0;
                            end
                        end
                        plob_pkg::OP_FIN_A: begin
                            r_pbs   <= r_idx;
                            r_pb_ok <= 1'b1;
                        end
                        plob_pkg::OP_FIN_B: begin
                            r_pas   <= r_idx;
                            r_pa_ok <= 1'b1;
                        end
                        plob_pkg::OP_RST: begin
                            r_bb_ok <= 1'b0;
                            r_ba_ok <= 1'b0;
                            r_pb_ok <= 1'b0;
                            r_pa_ok <= 1'b0;
                            r_ci    <= '0;
                            if (r_pa > 0) begin
                                r_base   <= r_pa;
                                r_mapped <= 1'b1;
                                r_cnt    <= r_cnt + 32'd1;
                            end else begin
                                r_base   <= '0;
                                r_mapped <= 1'b0;
                            end
                        end
                        default: begin
                            if (w_improve) begin
                                if (w_side) begin
                                    r_ba    <= w_addr;
                                    r_ba_ok <= 1'b1;
                                end else begin
                                    r_bb    <= w_addr;
                                    r_bb_ok <= 1'b1;
                                end
                            end
                            if (w_scan) begin
                                r_sside <= w_side;
                                if (w_side) begin
                                    r_si <= w_addr;
                                end else if (w_addr == '0) begin
                                    r_bb_ok <= 1'b0;
                                end else begin
                                    r_si <= w_addr - 1'b1;
                                end
                            end
                        end
                    endcase
                end
                plob_pkg::S_CLR: begin
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == plob_pkg::LVL_MAX) begin
                        r_boot <= 1'b0;
                    end
                end
                plob_pkg::S_DIVW: begin
                    if (div_rsp.done) begin
                        r_idx <= div_rsp.idx;
                    end
                end
                plob_pkg::S_SCCK: begin
                    if (w_rd != '0) begin
                        if (r_sside) begin
                            r_ba    <= r_si;
                            r_ba_ok <= 1'b1;
                        end else begin
                            r_bb    <= r_si;
                            r_bb_ok <= 1'b1;
                        end
                    end else if (w_scan_end) begin
                        if (r_sside) begin
                            r_ba_ok <= 1'b0;
                        end else begin
                            r_bb_ok <= 1'b0;
                        end
                    end else if (r_sside) begin
                        r_si <= r_si + 1'b1;
                    end else begin
                        r_si <= r_si - 1'b1;
                    end
                end
                plob_pkg::S_OMB: begin
                    r_bsz  <= bid_rd;
                    r_asz  <= ask_rd;
                    r_prod <= w_prod;
                end
                plob_pkg::S_OMA: begin
                    r_bp   <= w_sat;
                    r_prod <= w_prod;
                end
                plob_pkg::S_OAD: begin
                    if (w_out_adv) begin
                        r_oacc   <= r_acc;
                        r_oqv    <= r_bb_ok && r_ba_ok;
                        r_obp    <= (r_bb_ok && r_ba_ok) ? r_bp : '0;
                        r_obs    <= (r_bb_ok && r_ba_ok) ? r_bsz : '0;
                        r_oap    <= (r_bb_ok && r_ba_ok) ? w_sat : '0;
                        r_oas    <= (r_bb_ok && r_ba_ok) ? r_asz : '0;
                        r_ocnt   <= r_cnt;
                    end
                end
                default: begin
                    r_ci <= r_ci;
                end
            endcase
        end
    end

    assign o_in_ready       = (r_st == plob_pkg::S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_accepted       = r_oacc;
    assign o_quote_valid    = r_oqv;
    assign o_best_bid_price = r_obp;
    assign o_best_bid_size  = r_obs;
    assign o_best_ask_price = r_oap;
    assign o_best_ask_size  = r_oas;
    assign o_recenter_total = r_ocnt;

endmodule

// ===== hdl/plob_chk.sv =====
// port level checks of the order book core and their binding
module plob_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_quote_valid,
    input logic signed [31:0] o_best_bid_price,
    input logic [30:0]        o_best_bid_size,
    input logic signed [31:0] o_best_ask_price,
    input logic [30:0]        o_best_ask_size
);

    // an input transfer starts an item and drops o_in_ready
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after input transfer");

    // no quote means all quote fields read zero
    a_empty_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_quote_valid) |->
        (o_best_bid_price == 0 && o_best_ask_price == 0 &&
         o_best_bid_size == 0 && o_best_ask_size == 0))
        else $error("quote fields nonzero without a quote");

    // a valid quote shows a nonzero size on both best levels
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_quote_valid) |-> (o_best_bid_size != 0 && o_best_ask_size != 0))
        else $error("best level with zero size");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_best_bid_price) && $stable(o_best_ask_price)))
        else $error("stalled result changed");

endmodule

bind price_level_order_book_core plob_chk u_plob_chk (.*);
